[rtl/rgta_pkg.sv]
// shared types and constants for the rds group text assembler
package rgta_pkg;

    localparam int TEXT_CHARS    = 64;
    localparam int SERVICE_CHARS = 8;
    localparam int LANES         = 4;
    localparam int SEG_W         = 4;
    localparam int SEGS          = 1 << SEG_W;
    localparam int LEN_W         = 7;
    localparam int SVC_IDX_W     = $clog2(SERVICE_CHARS);
    localparam int WORD_W        = 8 * LANES;

    localparam logic [7:0]       CH_LF      = 8'h0A;
    localparam logic [7:0]       CH_CR      = 8'h0D;
    localparam logic [7:0]       CH_SPACE   = 8'h20;
    localparam logic [7:0]       CH_HIGHEST = 8'h7D;
    localparam logic [SEG_W-1:0] SEG_LAST   = 4'hF;
    localparam logic [4:0]       GRP_2A     = 5'b00100;
    localparam logic [3:0]       GRP_0      = 4'h0;
    localparam logic [LEN_W-1:0] LEN_FULL   = LEN_W'(TEXT_CHARS);

    // request function codes
    typedef enum logic [1:0] {
        FN_GROUP        = 2'd0,
        FN_READ_SERVICE = 2'd1,
        FN_READ_TEXT    = 2'd2,
        FN_CLEAR        = 2'd3
    } func_t;

    // where the read character of a result comes from
    typedef enum logic [1:0] {
        RD_NONE    = 2'd0,
        RD_SERVICE = 2'd1,
        RD_TEXT    = 2'd2,
        RD_BLANK   = 2'd3
    } rd_src_t;

    // what one character lane reports
    typedef struct packed {
        logic [7:0] text_char;
        logic       is_cr;
        logic [7:0] ps_char;
    } lane_res_t;

    // merged decision for a 2A segment
    typedef struct packed {
        logic             match;
        logic             ready;
        logic             publish;
        logic [LEN_W-1:0] len;
        logic [SEG_W-1:0] exp_next;
    } seg_dec_t;

endpackage

[rtl/rgta_char_lane.sv]
// one character lane: radiotext LF/CR handling and service character cleanup
module rgta_char_lane (
    input  logic [7:0]          char_in,
    output rgta_pkg::lane_res_t lane
);
    import rgta_pkg::*;

    // radiotext: LF shows as a space, CR flags message end
    // service name: anything outside the printable range shows as a space
    always_comb
    begin
        lane.text_char = (char_in == CH_LF) ? CH_SPACE : char_in;
        lane.is_cr     = (char_in == CH_CR);
        if (char_in < CH_SPACE || char_in > CH_HIGHEST)
            lane.ps_char = CH_SPACE;
        else
            lane.ps_char = char_in;
    end

endmodule

[rtl/rgta_merge.sv]
// merges the lane results of a 2A segment into length and publish decision
module rgta_merge (
    input  logic [rgta_pkg::SEG_W-1:0] seg,
    input  logic                       ab_flag,
    input  logic [rgta_pkg::SEG_W-1:0] expected_seg,
    input  logic                       last_ab,
    input  logic [rgta_pkg::LANES-1:0] cr_hits,
    output rgta_pkg::seg_dec_t         dec
);
    import rgta_pkg::*;

    logic [1:0]       first_cr;
    logic [LEN_W-1:0] base;

    // first lane holding a CR wins
    always_comb
    begin
        first_cr = '0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (cr_hits[i])
                first_cr = 2'(i);
        end
    end

    assign base = {1'b0, seg, 2'b00};

    // length, message end and next expected segment
    always_comb
    begin
        dec.match   = (seg == expected_seg);
        dec.ready   = |cr_hits;
        dec.len     = dec.ready ? (base + LEN_W'(first_cr)) : (base + LEN_W'(LANES));
        dec.publish = dec.match && (dec.ready || seg == SEG_LAST) && (ab_flag != last_ab);
        if (dec.ready || seg == SEG_LAST)
            dec.exp_next = '0;
        else
            dec.exp_next = expected_seg + SEG_W'(1);
    end

endmodule

[rtl/rgta_text_store.sv]
// two-bank radiotext memory, one segment word per row, registered read
module rgta_text_store (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [rgta_pkg::SEG_W:0]                wr_addr,
    input  logic [rgta_pkg::WORD_W-1:0]             wr_data,
    input  logic                                    rd_en,
    input  logic [rgta_pkg::SEG_W:0]                rd_addr,
    output logic [rgta_pkg::WORD_W-1:0]             rd_data
);
    import rgta_pkg::*;

    logic [WORD_W-1:0] mem [2*SEGS];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

[rtl/rds_group_text_assembler.sv]
// top level of the rds group text assembler
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  input    | in_valid/in_ready  | func, block_b, block_c, block_d, read_index
//  output   | out_valid/out_ready| read_char, ps_written, rt_published,
//           |                    | rt_length, frame_lost
//
//  one request per cycle while no held result stalls input; each result appears in the
//  cycle after its request, set by the registered read of the radiotext memory
//  the four characters of a group are handled in four lanes in the same cycle
//  a held result stalls input only when out_ready is low
//  reset brings spaces in service name and published text, length 64;
//  no clearing pass is needed
module rds_group_text_assembler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [15:0] block_b,
    input  logic [15:0] block_c,
    input  logic [15:0] block_d,
    input  logic [5:0]  read_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_char,
    output logic        ps_written,
    output logic        rt_published,
    output logic [6:0]  rt_length,
    output logic        frame_lost
);
    import rgta_pkg::*;

    func_t                 fn;
    logic                  in_acc;
    logic                  grp0;
    logic                  is2a;
    logic                  ps_ev;
    logic                  rt_ev;
    logic                  pub_ev;
    logic                  clr_ev;
    logic [7:0]            lane_in [LANES];
    lane_res_t             lane_res [LANES];
    logic [LANES-1:0]      cr_hits;
    seg_dec_t              dec;
    logic [WORD_W-1:0]     wr_data;
    logic [WORD_W-1:0]     rd_data;

    // control state
    logic [SEG_W-1:0]      exp_seg_reg, exp_seg_next;
    logic                  last_ab_reg, last_ab_next;
    logic                  pub_bank_reg, pub_bank_next;
    logic                  blank_reg, blank_next;
    logic [LEN_W-1:0]      pub_len_reg, pub_len_next;
    logic [7:0]            svc_reg [SERVICE_CHARS];
    logic [7:0]            svc_next [SERVICE_CHARS];

    // output stage
    logic                  out_valid_reg, out_valid_next;
    logic                  ps_reg;
    logic                  pub_reg;
    logic                  lost_reg;
    logic [LEN_W-1:0]      len_reg;
    rd_src_t               src_reg, src_next;
    logic [7:0]            svc_char_reg;
    logic [1:0]            lane_sel_reg;

    assign fn       = func_t'(func);
    assign in_ready = !out_valid_reg || out_ready;
    assign in_acc   = in_valid && in_ready;
    assign grp0     = (block_b[15:12] == GRP_0);
    assign is2a     = (block_b[15:11] == GRP_2A);
    assign ps_ev    = in_acc && (fn == FN_GROUP) && grp0;
    assign rt_ev    = in_acc && (fn == FN_GROUP) && is2a;
    assign pub_ev   = rt_ev && dec.publish;
    assign clr_ev   = in_acc && (fn == FN_CLEAR);

    // character lanes, in text order
    assign lane_in[0] = block_c[15:8];
    assign lane_in[1] = block_c[7:0];
    assign lane_in[2] = block_d[15:8];
    assign lane_in[3] = block_d[7:0];

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        rgta_char_lane u_lane (
            .char_in (lane_in[g]),
            .lane    (lane_res[g])
        );
        assign cr_hits[g] = lane_res[g].is_cr;
        assign wr_data[WORD_W-1-8*g -: 8] = lane_res[g].text_char;
    end

    rgta_merge u_merge (
        .seg          (block_b[SEG_W-1:0]),
        .ab_flag      (block_b[4]),
        .expected_seg (exp_seg_reg),
        .last_ab      (last_ab_reg),
        .cr_hits      (cr_hits),
        .dec          (dec)
    );

    // work bank is the one not published
    rgta_text_store u_store (
        .clk     (clk),
        .wr_en   (rt_ev && dec.match),
        .wr_addr ({!pub_bank_reg, block_b[SEG_W-1:0]}),
        .wr_data (wr_data),
        .rd_en   (in_acc && (fn == FN_READ_TEXT)),
        .rd_addr ({pub_bank_reg, read_index[5:2]}),
        .rd_data (rd_data)
    );

    // next control state
    always_comb
    begin
        exp_seg_next  = exp_seg_reg;
        last_ab_next  = last_ab_reg;
        pub_bank_next = pub_bank_reg;
        blank_next    = blank_reg;
        pub_len_next  = pub_len_reg;
        svc_next      = svc_reg;
        if (rt_ev)
            exp_seg_next = dec.match ? dec.exp_next : '0;
        if (pub_ev)
        begin
            last_ab_next  = block_b[4];
            pub_bank_next = !pub_bank_reg;
            blank_next    = 1'b0;
            pub_len_next  = dec.len;
        end
        if (ps_ev)
        begin
            svc_next[{block_b[1:0], 1'b0}] = lane_res[2].ps_char;
            svc_next[{block_b[1:0], 1'b1}] = lane_res[3].ps_char;
        end
        if (clr_ev)
        begin
            exp_seg_next = '0;
            blank_next   = 1'b1;
            pub_len_next = LEN_FULL;
            for (int i = 0; i < SERVICE_CHARS; i++)
                svc_next[i] = CH_SPACE;
        end
    end

    // read source of the result
    always_comb
    begin
        case (fn)
            FN_READ_SERVICE:
                src_next = (read_index < 6'(SERVICE_CHARS)) ? RD_SERVICE : RD_NONE;
            FN_READ_TEXT:
                if ({1'b0, read_index} < pub_len_reg)
                    src_next = blank_reg ? RD_BLANK : RD_TEXT;
                else
                    src_next = RD_NONE;
            default:
                src_next = RD_NONE;
        endcase
    end

    always_comb
    begin
        if (in_acc)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_seg_reg   <= '0;
            last_ab_reg   <= 1'b0;
            pub_bank_reg  <= 1'b0;
            blank_reg     <= 1'b1;
            pub_len_reg   <= LEN_FULL;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SERVICE_CHARS; i++)
                svc_reg[i] <= CH_SPACE;
        end
        else
        begin
            exp_seg_reg   <= exp_seg_next;
            last_ab_reg   <= last_ab_next;
            pub_bank_reg  <= pub_bank_next;
            blank_reg     <= blank_next;
            pub_len_reg   <= pub_len_next;
            out_valid_reg <= out_valid_next;
            svc_reg       <= svc_next;
        end
    end

    // result payload, loaded with each request
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ps_reg       <= ps_ev;
            pub_reg      <= pub_ev;
            lost_reg     <= rt_ev && !dec.match;
            len_reg      <= pub_len_next;
            src_reg      <= src_next;
            svc_char_reg <= svc_reg[read_index[SVC_IDX_W-1:0]];
            lane_sel_reg <= read_index[1:0];
        end
    end

    // read character select
    always_comb
    begin
        case (src_reg)
            RD_SERVICE: read_char = svc_char_reg;
            RD_TEXT:    read_char = rd_data[WORD_W-1-8*lane_sel_reg -: 8];
            RD_BLANK:   read_char = CH_SPACE;
            default:    read_char = 8'h00;
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign ps_written   = ps_reg;
    assign rt_published = pub_reg;
    assign rt_length    = len_reg;
    assign frame_lost   = lost_reg;

    // a publish swaps the banks and unblanks the text
    a_pub_swap: assert property (@(posedge clk) disable iff (!rst_n)
        pub_ev |=> (pub_bank_reg != $past(pub_bank_reg)) && !blank_reg)
        else $error("publish did not swap banks");

    // a lost frame or a clear restarts segment sync
    a_sync_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (clr_ev || (rt_ev && !dec.match)) |=> (exp_seg_reg == '0))
        else $error("segment sync not reset");

    // a clear leaves a full blank text
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_ev |=> blank_reg && (pub_len_reg == LEN_FULL))
        else $error("clear left stale text");

    // result flags are exclusive
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $countones({ps_reg, pub_reg, lost_reg}) <= 1)
        else $error("conflicting result flags");

    // published length stays within the text
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        pub_ev |-> (dec.len <= LEN_FULL) && (dec.len != '0 || cr_hits[0]))
        else $error("bad publish length");

endmodule

[verif/rgta_result_checker.sv]
// result checker for the rds group text assembler: predicts every result and compares
module rgta_result_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  rgta_pkg::func_t  func,
    input  logic [15:0]      block_b,
    input  logic [15:0]      block_c,
    input  logic [15:0]      block_d,
    input  logic [5:0]       read_index,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [7:0]       read_char,
    input  logic             ps_written,
    input  logic             rt_published,
    input  logic [6:0]       rt_length,
    input  logic             frame_lost,
    output int               errors,
    output int               in_flight
);
    import rgta_pkg::*;

    // one expected result
    typedef struct packed {
        logic [7:0]       ch;
        logic             ps;
        logic             pub;
        logic [LEN_W-1:0] len;
        logic             lost;
    } rds_result_t;

    // predicted block state
    logic [7:0]       ps_name   [SERVICE_CHARS];
    logic [7:0]       rt_work   [TEXT_CHARS];
    logic [7:0]       rt_shown  [TEXT_CHARS];
    logic [LEN_W-1:0] shown_len;
    logic [SEG_W-1:0] seg_expect;
    logic             ab_last;

    rds_result_t expected_results[$];
    rds_result_t want_res;
    rds_result_t got_res;
    int          bad;
    int          delta;

    initial errors = 0;

    // service characters outside the printable range read as space
    function automatic logic [7:0] printable(input logic [7:0] c);
        return (c < CH_SPACE || c > CH_HIGHEST) ? CH_SPACE : c;
    endfunction

    // station change: blank service name and published text
    function automatic void clear_texts();
        for (int k = 0; k < SERVICE_CHARS; k++)
            ps_name[k] = CH_SPACE;
        for (int k = 0; k < TEXT_CHARS; k++)
            rt_shown[k] = CH_SPACE;
        shown_len  = LEN_FULL;
        seg_expect = '0;
    endfunction

    // apply one request to the predicted state and return its result
    function automatic rds_result_t assemble_text(input func_t fn, input logic [15:0] b,
                                                  input logic [15:0] c, input logic [15:0] d,
                                                  input logic [5:0] idx);
        rds_result_t      r;
        logic [7:0]       lane_chars [LANES];
        logic [LEN_W-1:0] base;
        logic [LEN_W-1:0] msg_len;
        logic [SEG_W-1:0] seg;
        logic             cr_seen;
        int               slot;
        int               k;
        r = '0;
        case (fn)
            FN_GROUP:
            begin
                // group 0: two service characters
                if (b[15:12] == GRP_0)
                begin
                    slot = 2 * int'(b[1:0]);
                    ps_name[slot]     = printable(d[15:8]);
                    ps_name[slot + 1] = printable(d[7:0]);
                    r.ps = 1'b1;
                end
                // group 2A: four radiotext characters, in segment order only
                if (b[15:11] == GRP_2A)
                begin
                    seg = b[3:0];
                    if (seg == seg_expect)
                    begin
                        base = LEN_W'(4 * int'(seg));
                        lane_chars = '{c[15:8], c[7:0], d[15:8], d[7:0]};
                        for (k = 0; k < LANES; k++)
                            rt_work[base + k] = lane_chars[k];
                        cr_seen = 1'b0;
                        msg_len = base + LEN_W'(LANES);
                        for (k = 0; k < LANES && !cr_seen; k++)
                        begin
                            if (rt_work[base + k] == CH_LF)
                                rt_work[base + k] = CH_SPACE;
                            if (rt_work[base + k] == CH_CR)
                            begin
                                cr_seen = 1'b1;
                                msg_len = base + LEN_W'(k);
                            end
                        end
                        if (!cr_seen)
                            seg_expect = seg_expect + 1'b1;
                        // message end: publish only on a new a/b flag
                        if (cr_seen || seg == SEG_LAST)
                        begin
                            if (b[4] != ab_last)
                            begin
                                for (k = 0; k < msg_len; k++)
                                    rt_shown[k] = rt_work[k];
                                shown_len = msg_len;
                                ab_last   = b[4];
                                r.pub     = 1'b1;
                            end
                            seg_expect = '0;
                        end
                    end
                    else
                    begin
                        seg_expect = '0;
                        r.lost     = 1'b1;
                    end
                end
            end
            FN_READ_SERVICE:
            begin
                if (idx < SERVICE_CHARS)
                    r.ch = ps_name[idx[2:0]];
            end
            FN_READ_TEXT:
            begin
                if (idx < shown_len)
                    r.ch = rt_shown[idx];
            end
            default:
            begin
                clear_texts();
            end
        endcase
        r.len = shown_len;
        return r;
    endfunction

    // report one differing field, returns 1 on a mismatch
    function automatic int check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t %s mismatch: expected %02h actual %02h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // predict on each accepted request, compare on each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_texts();
            for (int k = 0; k < TEXT_CHARS; k++)
                rt_work[k] = 8'h00;
            ab_last = 1'b0;
            expected_results.delete();
            in_flight <= 0;
        end
        else
        begin
            bad   = 0;
            delta = 0;
            if (in_valid && in_ready)
            begin
                expected_results.push_back(
                    assemble_text(func, block_b, block_c, block_d, read_index));
                delta++;
            end
            if (out_valid && out_ready)
            begin
                got_res = '{read_char, ps_written, rt_published, rt_length, frame_lost};
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected result: expected none actual %p", $time, got_res);
                    bad++;
                end
                else
                begin
                    want_res = expected_results.pop_front();
                    delta--;
                    bad += check_field("read_char", want_res.ch, got_res.ch);
                    bad += check_field("ps_written", 8'(want_res.ps), 8'(got_res.ps));
                    bad += check_field("rt_published", 8'(want_res.pub), 8'(got_res.pub));
                    bad += check_field("rt_length", 8'(want_res.len), 8'(got_res.len));
                    bad += check_field("frame_lost", 8'(want_res.lost), 8'(got_res.lost));
                end
            end
            errors    <= errors + bad;
            in_flight <= in_flight + delta;
        end
    end

endmodule

[verif/tb_rds_group_text_assembler.sv]
// testbench top for the rds group text assembler: stimulus, flow control and verdict
module tb_rds_group_text_assembler;
    import rgta_pkg::*;

    localparam int ITEMS_PER_PHASE = 175;
    localparam int LONG_HOLD       = 150;
    localparam int DRAIN_SLACK     = 4;
    localparam int CYCLE_LIMIT     = 400000;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    func_t       func         = FN_GROUP;
    logic [15:0] block_b      = '0;
    logic [15:0] block_c      = '0;
    logic [15:0] block_d      = '0;
    logic [5:0]  read_index   = '0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [7:0]  read_char;
    logic        ps_written;
    logic        rt_published;
    logic [6:0]  rt_length;
    logic        frame_lost;

    int          result_errors;
    int          in_flight;
    int          cycle_count    = 0;
    int          sent_count     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          hold_go        = 1'b0;
    bit          hold_done      = 1'b0;
    logic        cur_ab         = 1'b0;

    rds_group_text_assembler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .block_b      (block_b),
        .block_c      (block_c),
        .block_d      (block_d),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_char    (read_char),
        .ps_written   (ps_written),
        .rt_published (rt_published),
        .rt_length    (rt_length),
        .frame_lost   (frame_lost)
    );

    rgta_result_checker result_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .block_b      (block_b),
        .block_c      (block_c),
        .block_d      (block_d),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_char    (read_char),
        .ps_written   (ps_written),
        .rt_published (rt_published),
        .rt_length    (rt_length),
        .frame_lost   (frame_lost),
        .errors       (result_errors),
        .in_flight    (in_flight)
    );

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // offer one request, with random idle cycles ahead of it
    task automatic send_request(input func_t fn, input logic [15:0] b, input logic [15:0] c,
                                input logic [15:0] d, input logic [5:0] idx);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= fn;
        block_b    <= b;
        block_c    <= c;
        block_d    <= d;
        read_index <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
    endtask

    // one 2A radiotext segment
    task automatic send_segment(input logic ab, input logic [3:0] seg,
                                input logic [15:0] c, input logic [15:0] d);
        send_request(FN_GROUP, {GRP_2A, 6'($urandom), ab, seg}, c, d, 6'($urandom));
    endtask

    // stop offering until every outstanding result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    // mostly printable text with some line feeds, returns and raw bytes
    function automatic logic [7:0] text_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return CH_LF;
        if (pick < 8)
            return CH_CR;
        if (pick < 14)
            return 8'($urandom);
        return 8'($urandom_range(32, 126));
    endfunction

    // a radiotext message of several segments, optionally with a bad segment address
    task automatic send_radiotext(input logic ab, input int nsegs, input bit end_cr,
                                  input bit glitch);
        logic [7:0] ch [4];
        int         s;
        int         k;
        int         bad_seg;
        int         cr_lane;
        bad_seg = glitch ? $urandom_range(0, nsegs - 1) : -1;
        cr_lane = $urandom_range(0, 3);
        for (s = 0; s < nsegs; s++)
        begin
            for (k = 0; k < 4; k++)
                ch[k] = text_char();
            if (end_cr && s == nsegs - 1)
                ch[cr_lane] = CH_CR;
            send_segment(ab, (s == bad_seg) ? 4'($urandom) : 4'(s),
                         {ch[0], ch[1]}, {ch[2], ch[3]});
        end
    endtask

    // random traffic: radiotext messages as the largest share, plus service, reads, clears and noise
    task automatic random_phase(input int items);
        int   stop_at;
        int   pick;
        int   nsegs;
        logic ab;
        stop_at = sent_count + items;
        while (sent_count < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                nsegs = ($urandom_range(0, 4) == 0) ? 16 : $urandom_range(1, 8);
                ab = ($urandom_range(0, 3) == 0) ? cur_ab : ~cur_ab;
                cur_ab = ab;
                send_radiotext(ab, nsegs,
                               (nsegs < 16) ? ($urandom_range(0, 3) != 0)
                                            : ($urandom_range(0, 1) == 1),
                               $urandom_range(0, 9) == 0);
            end
            else if (pick < 60)
                send_request(FN_GROUP, {GRP_0, 12'($urandom)}, 16'($urandom),
                             16'($urandom), 6'($urandom));
            else if (pick < 80)
                send_request($urandom_range(0, 1) ? FN_READ_TEXT : FN_READ_SERVICE,
                             16'($urandom), 16'($urandom), 16'($urandom), 6'($urandom));
            else if (pick < 84)
                send_request(FN_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                             6'($urandom));
            else if (pick < 92)
                send_request(FN_GROUP, 16'($urandom), 16'($urandom), 16'($urandom),
                             6'($urandom));
            else
                send_request(func_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                             16'($urandom), 6'($urandom));
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int send_idle_set [4];
        int recv_stall_set [4];
        int s;
        send_idle_set  = '{0, 68, 0, 24};
        recv_stall_set = '{0, 0, 68, 24};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset contents and the service name filter
        send_request(FN_READ_SERVICE, 16'h0000, 16'h0000, 16'h0000, 6'd0);
        send_request(FN_READ_SERVICE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63);
        send_request(FN_READ_TEXT, 16'h0000, 16'h0000, 16'h0000, 6'd63);
        send_request(FN_GROUP, 16'h0003, 16'h0000, 16'h1F7E, 6'd0);
        send_request(FN_GROUP, 16'h0800, 16'hFFFF, 16'h207D, 6'd63);
        send_request(FN_READ_SERVICE, 16'h0000, 16'h0000, 16'h0000, 6'd7);
        send_request(FN_READ_SERVICE, 16'h0000, 16'h0000, 16'h0000, 6'd1);

        // full message of sixteen segments, line feed in segment 2
        for (s = 0; s < 16; s++)
            send_segment(1'b1, 4'(s),
                         {(s == 2) ? CH_LF : 8'(8'h41 + s), 8'(8'h61 + s)},
                         {8'(8'h30 + s), 8'h7E});
        send_request(FN_READ_TEXT, 16'h0000, 16'h0000, 16'h0000, 6'd8);

        // same a/b flag: message end without publish
        send_segment(1'b1, 4'd0, {"H", "i"}, {CH_CR, "x"});
        // wrong segment address
        send_segment(1'b0, 4'd5, {"z", "z"}, {"z", "z"});
        // new flag, line feed then return in the last lane
        send_segment(1'b0, 4'd0, {"O", "K"}, {CH_LF, CH_CR});
        send_request(FN_READ_TEXT, 16'h0000, 16'h0000, 16'h0000, 6'd2);
        send_request(FN_READ_TEXT, 16'h0000, 16'h0000, 16'h0000, 6'd3);
        cur_ab = 1'b0;

        // other group types are ignored
        send_request(FN_GROUP, 16'hF123, 16'h0D0D, 16'h0D0D, 6'd0);
        send_request(FN_GROUP, 16'h2800, 16'h0D0D, 16'h0D0D, 6'd0);

        // station change
        send_request(FN_CLEAR, 16'h0000, 16'h0000, 16'h0000, 6'd0);
        send_request(FN_READ_TEXT, 16'h0000, 16'h0000, 16'h0000, 6'd2);
        send_request(FN_READ_SERVICE, 16'h0000, 16'h0000, 16'h0000, 6'd6);
        drain();

        // random phases with different idle patterns, long hold-off in the first
        for (s = 0; s < 4; s++)
        begin
            send_idle_pct  = send_idle_set[s];
            recv_stall_pct = recv_stall_set[s];
            if (s == 0)
                hold_go = 1'b1;
            random_phase(ITEMS_PER_PHASE);
            drain();
        end

        if (result_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[rds_group_text_assembler.f]
rtl/rgta_pkg.sv
rtl/rgta_char_lane.sv
rtl/rgta_merge.sv
rtl/rgta_text_store.sv
rtl/rds_group_text_assembler.sv
verif/rgta_result_checker.sv
verif/tb_rds_group_text_assembler.sv
